// File: src/tick_driven_calendar_clock_assert.svh
// Assertion macros used by the checker of the calendar clock.
`ifndef TICK_DRIVEN_CALENDAR_CLOCK_ASSERT_SVH
`define TICK_DRIVEN_CALENDAR_CLOCK_ASSERT_SVH

// Checked only while the block is out of reset.
`define TDCC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define TDCC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/tdcc_pkg.sv
// Package with the types and constants of the tick-driven calendar clock.
package tdcc_pkg;

    localparam int COUNT_WIDTH = 32;

    localparam int RATE_WIDTH    = 16;
    localparam int SUB_WIDTH     = 16;
    localparam int IN_DATA_WIDTH = 48;
    localparam int OUT_DATA_WIDTH = 80;

    localparam logic [RATE_WIDTH-1:0] RESET_TICK_RATE = 16'd1000;

    localparam logic [6:0]  SECS_PER_MIN    = 7'd60;
    localparam logic [6:0]  MINS_PER_HOUR   = 7'd60;
    localparam logic [5:0]  HOURS_PER_DAY   = 6'd24;
    localparam logic [5:0]  DAYS_PER_MONTH  = 6'd30;
    localparam logic [4:0]  MONTHS_PER_YEAR = 5'd12;

    localparam logic [5:0]  RESET_SECONDS = 6'd0;
    localparam logic [5:0]  RESET_MINUTES = 6'd0;
    localparam logic [4:0]  RESET_HOURS   = 5'd12;
    localparam logic [4:0]  RESET_DAY     = 5'd1;
    localparam logic [3:0]  RESET_MONTH   = 4'd1;
    localparam logic [15:0] RESET_YEAR    = 16'd2024;

    localparam logic [0:0] MODE_TICK = 1'b0;
    localparam logic [0:0] MODE_SET  = 1'b1;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
    } calendar_t;

endpackage

// File: src/tdcc_calendar.sv
// Combinational one-second advance of the calendar fields with carry.
module tdcc_calendar (
    input  tdcc_pkg::calendar_t cur,
    output tdcc_pkg::calendar_t nxt
);

    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [5:0] hrs_inc;
    logic [5:0] day_inc;
    logic [4:0] mon_inc;

    assign sec_inc = {1'b0, cur.seconds} + 7'd1;
    assign min_inc = {1'b0, cur.minutes} + 7'd1;
    assign hrs_inc = {1'b0, cur.hours} + 6'd1;
    assign day_inc = {1'b0, cur.day} + 6'd1;
    assign mon_inc = {1'b0, cur.month} + 5'd1;

    always_comb begin
        nxt = cur;
        if (sec_inc < tdcc_pkg::SECS_PER_MIN) begin
            nxt.seconds = sec_inc[5:0];
        end else begin
            nxt.seconds = 6'd0;
            if (min_inc < tdcc_pkg::MINS_PER_HOUR) begin
                nxt.minutes = min_inc[5:0];
            end else begin
                nxt.minutes = 6'd0;
                if (hrs_inc < tdcc_pkg::HOURS_PER_DAY) begin
                    nxt.hours = hrs_inc[4:0];
                end else begin
                    nxt.hours = 5'd0;
                    if (day_inc <= tdcc_pkg::DAYS_PER_MONTH) begin
                        nxt.day = day_inc[4:0];
                    end else begin
                        nxt.day = 5'd1;
                        if (mon_inc <= tdcc_pkg::MONTHS_PER_YEAR) begin
                            nxt.month = mon_inc[3:0];
                        end else begin
                            nxt.month = 4'd1;
                            nxt.year  = cur.year + 16'd1;
                        end
                    end
                end
            end
        end
    end

endmodule

// File: src/tick_driven_calendar_clock.sv
// Top level of the tick-driven calendar clock.
// An accepted input transaction reaches the m_ side through the input register and then the output register.
// Throughput: one transaction per cycle while m_tready does not stall; the calendar carry chain is combinational.
// Backpressure on m_tready stalls the output register and then the input register.
// Reset (aresetn low, synchronous) empties both stages, sets the tick rate to 1000,
// clears the counters and loads the calendar with 12:00:00 on day 1, month 1, 2024.
module tick_driven_calendar_clock (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [tdcc_pkg::RATE_WIDTH-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // set_seconds, set_minutes, set_hours, set_day, set_month, set_year, zero pad
    input  logic [tdcc_pkg::IN_DATA_WIDTH-1:0]  s_tdata,
    // mode
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tick_count, seconds, minutes, hours, day, month, year, zero pad
    output logic [tdcc_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
    // second_strobe
    output logic                                m_tuser
);

    logic                                 in_valid_reg;
    logic                                 in_mode_reg;
    tdcc_pkg::calendar_t                  in_cal_reg;

    logic [tdcc_pkg::RATE_WIDTH-1:0]      rate_reg;
    logic [tdcc_pkg::COUNT_WIDTH-1:0]     tick_reg;
    logic [tdcc_pkg::COUNT_WIDTH-1:0]     tick_next;
    logic [tdcc_pkg::SUB_WIDTH-1:0]       sub_reg;
    logic [tdcc_pkg::SUB_WIDTH-1:0]       sub_next;
    tdcc_pkg::calendar_t                  cal_reg;
    tdcc_pkg::calendar_t                  cal_next;
    tdcc_pkg::calendar_t                  cal_adv;
    logic [tdcc_pkg::SUB_WIDTH:0]         sub_inc;
    logic                                 sub_wrap;
    logic                                 strobe_next;

    logic                                 m_valid_reg;
    logic                                 m_valid_next;
    logic [31:0]                          m_tick_reg;
    tdcc_pkg::calendar_t                  m_cal_reg;
    logic                                 m_strobe_reg;

    logic                                 in_load;
    logic                                 out_load;

    assign out_load = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_mode_reg        <= s_tuser;
            in_cal_reg.seconds <= s_tdata[5:0];
            in_cal_reg.minutes <= s_tdata[11:6];
            in_cal_reg.hours   <= s_tdata[16:12];
            in_cal_reg.day     <= s_tdata[21:17];
            in_cal_reg.month   <= s_tdata[25:22];
            in_cal_reg.year    <= s_tdata[41:26];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= tdcc_pkg::RESET_TICK_RATE;
        end else if (cfg_we) begin
            rate_reg <= cfg_wdata;
        end
    end

    tdcc_calendar u_calendar (
        .cur (cal_reg),
        .nxt (cal_adv)
    );

    assign sub_inc  = {1'b0, sub_reg} + {{tdcc_pkg::SUB_WIDTH{1'b0}}, 1'b1};
    assign sub_wrap = sub_inc >= {1'b0, rate_reg};

    always_comb begin
        tick_next   = tick_reg;
        sub_next    = sub_reg;
        cal_next    = cal_reg;
        strobe_next = 1'b0;
        if (in_mode_reg == tdcc_pkg::MODE_SET) begin
            cal_next = in_cal_reg;
        end else begin
            tick_next = tick_reg + {{(tdcc_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1};
            if (sub_wrap) begin
                sub_next    = '0;
                strobe_next = 1'b1;
                cal_next    = cal_adv;
            end else begin
                sub_next = sub_inc[tdcc_pkg::SUB_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg        <= '0;
            sub_reg         <= '0;
            cal_reg.seconds <= tdcc_pkg::RESET_SECONDS;
            cal_reg.minutes <= tdcc_pkg::RESET_MINUTES;
            cal_reg.hours   <= tdcc_pkg::RESET_HOURS;
            cal_reg.day     <= tdcc_pkg::RESET_DAY;
            cal_reg.month   <= tdcc_pkg::RESET_MONTH;
            cal_reg.year    <= tdcc_pkg::RESET_YEAR;
        end else if (out_load) begin
            tick_reg <= tick_next;
            sub_reg  <= sub_next;
            cal_reg  <= cal_next;
        end
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tick_reg   <= 32'(tick_next);
            m_cal_reg    <= cal_next;
            m_strobe_reg <= strobe_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_strobe_reg;
    assign m_tdata  = {6'd0, m_cal_reg.year, m_cal_reg.month, m_cal_reg.day,
                       m_cal_reg.hours, m_cal_reg.minutes, m_cal_reg.seconds, m_tick_reg};

endmodule

// File: src/tdcc_checker.sv
// Port-level checker of the calendar clock and its bind to the top level.
`include "tick_driven_calendar_clock_assert.svh"

module tdcc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [tdcc_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
    input logic                                m_tuser
);

    `TDCC_ASSERT_ALWAYS(a_reset_empties_output, aclk, !aresetn |=> !m_tvalid, "m_tvalid high after reset")
    `TDCC_ASSERT(a_stall_holds_result, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result transaction changed")
    `TDCC_ASSERT(a_strobe_seconds_in_range, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata[37:32] < 6'd60, "second strobe with seconds out of range")
    `TDCC_ASSERT(a_ready_when_output_free, aclk, aresetn, !m_tvalid |-> s_tready, "input stalled while output register is free")

endmodule

bind tick_driven_calendar_clock tdcc_checker u_tdcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: dv/tick_driven_calendar_clock_tb.sv
// Self-checking testbench for the tick-driven calendar clock.
`timescale 1ns / 100ps

module tick_driven_calendar_clock_tb;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [0:0]          mode;
        tdcc_pkg::calendar_t cal;
    } clock_cmd_t;

    typedef struct {
        logic [31:0]         ticks;
        tdcc_pkg::calendar_t cal;
        logic                strobe;
    } clock_result_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                cfg_we = 1'b0;
    logic [tdcc_pkg::RATE_WIDTH-1:0]     cfg_wdata = '0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [tdcc_pkg::IN_DATA_WIDTH-1:0]  s_tdata = '0;
    logic                                s_tuser = 1'b0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [tdcc_pkg::OUT_DATA_WIDTH-1:0] m_tdata;
    logic                                m_tuser;

    clock_cmd_t    pending_cmds[$];
    clock_result_t expected_results[$];
    clock_cmd_t    offered_cmd;

    logic [tdcc_pkg::RATE_WIDTH-1:0] rate_q = tdcc_pkg::RESET_TICK_RATE;
    logic [31:0]                     ticks_q = '0;
    logic [tdcc_pkg::SUB_WIDTH-1:0]  subsec_q = '0;
    tdcc_pkg::calendar_t             cal_q = '{tdcc_pkg::RESET_YEAR, tdcc_pkg::RESET_MONTH,
                                               tdcc_pkg::RESET_DAY, tdcc_pkg::RESET_HOURS,
                                               tdcc_pkg::RESET_MINUTES,
                                               tdcc_pkg::RESET_SECONDS};

    bit src_idle = 1'b0;
    bit sink_idle = 1'b0;
    bit hold_kick = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int error_count = 0;

    tick_driven_calendar_clock i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void advance_one_second();
        if (({1'b0, cal_q.seconds} + 7'd1) < tdcc_pkg::SECS_PER_MIN) begin
            cal_q.seconds = cal_q.seconds + 6'd1;
            return;
        end
        cal_q.seconds = '0;
        if (({1'b0, cal_q.minutes} + 7'd1) < tdcc_pkg::MINS_PER_HOUR) begin
            cal_q.minutes = cal_q.minutes + 6'd1;
            return;
        end
        cal_q.minutes = '0;
        if (({1'b0, cal_q.hours} + 6'd1) < tdcc_pkg::HOURS_PER_DAY) begin
            cal_q.hours = cal_q.hours + 5'd1;
            return;
        end
        cal_q.hours = '0;
        if (({1'b0, cal_q.day} + 6'd1) <= tdcc_pkg::DAYS_PER_MONTH) begin
            cal_q.day = cal_q.day + 5'd1;
            return;
        end
        cal_q.day = 5'd1;
        if (({1'b0, cal_q.month} + 5'd1) <= tdcc_pkg::MONTHS_PER_YEAR) begin
            cal_q.month = cal_q.month + 4'd1;
            return;
        end
        cal_q.month = 4'd1;
        cal_q.year = cal_q.year + 16'd1;
    endfunction

    function automatic void predict_clock(input clock_cmd_t cmd);
        clock_result_t res;
        logic [tdcc_pkg::SUB_WIDTH:0] next_sub;
        res.strobe = 1'b0;
        if (cmd.mode == tdcc_pkg::MODE_SET) begin
            cal_q = cmd.cal;
        end else begin
            ticks_q = ticks_q + 32'd1;
            next_sub = {1'b0, subsec_q} + 1'b1;
            if (next_sub >= {1'b0, rate_q}) begin
                subsec_q = '0;
                res.strobe = 1'b1;
                advance_one_second();
            end else begin
                subsec_q = next_sub[tdcc_pkg::SUB_WIDTH-1:0];
            end
        end
        res.ticks = ticks_q;
        res.cal = cal_q;
        expected_results.push_back(res);
    endfunction

    function automatic int near_top(input int top);
        int r;
        r = $urandom_range(0, 3);
        if (r == 0) return top;
        if (r == 1) return top - 1;
        return $urandom_range(0, top);
    endfunction

    function automatic clock_cmd_t random_command();
        clock_cmd_t cmd;
        int r;
        r = $urandom_range(0, 99);
        cmd.cal = tdcc_pkg::calendar_t'({$urandom, $urandom});
        cmd.mode = tdcc_pkg::MODE_TICK;
        if (r >= 65) begin
            cmd.mode = tdcc_pkg::MODE_SET;
            if (r < 92) begin
                cmd.cal.seconds = 6'(near_top(59));
                cmd.cal.minutes = 6'(near_top(59));
                cmd.cal.hours = 5'(near_top(23));
                cmd.cal.day = 5'(near_top(29) + 1);
                cmd.cal.month = 4'(near_top(11) + 1);
                if ($urandom_range(0, 3) == 0) cmd.cal.year = 16'hFFFF;
            end
        end
        return cmd;
    endfunction

    task automatic queue_tick();
        clock_cmd_t cmd;
        cmd.mode = tdcc_pkg::MODE_TICK;
        cmd.cal = tdcc_pkg::calendar_t'({$urandom, $urandom});
        pending_cmds.push_back(cmd);
    endtask

    task automatic queue_set(input int sec, input int min, input int hr, input int dy,
                             input int mon, input int yr);
        clock_cmd_t cmd;
        cmd.mode = tdcc_pkg::MODE_SET;
        cmd.cal = '{16'(yr), 4'(mon), 5'(dy), 5'(hr), 6'(min), 6'(sec)};
        pending_cmds.push_back(cmd);
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++) begin
            pending_cmds.push_back(random_command());
        end
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_tick_rate(input logic [tdcc_pkg::RATE_WIDTH-1:0] rate);
        wait_drained();
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= rate;
        @(posedge aclk);
        cfg_we <= 1'b0;
        rate_q = rate;
        @(negedge aclk);
    endtask

    task automatic random_phase(input logic [tdcc_pkg::RATE_WIDTH-1:0] rate, input int count);
        write_tick_rate(rate);
        src_idle = ($urandom_range(0, 2) != 0);
        sink_idle = ($urandom_range(0, 2) != 0);
        queue_random(count);
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            report_mismatch($sformatf("field %s is 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_clock(offered_cmd);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    offered_cmd <= pending_cmds[0];
                    s_tdata <= {6'b0, pending_cmds[0].cal};
                    s_tuser <= pending_cmds[0].mode;
                    void'(pending_cmds.pop_front());
                    s_tvalid <= 1'b1;
                    if (src_idle && $urandom_range(0, 5) == 0) begin
                        gap_left <= $urandom_range(1, 13);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        clock_result_t want;
        tdcc_pkg::calendar_t got_cal;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result transaction with none expected");
                end else begin
                    want = expected_results.pop_front();
                    got_cal = m_tdata[73:32];
                    report_field("tick_count", want.ticks, m_tdata[31:0]);
                    report_field("seconds", 32'(want.cal.seconds), 32'(got_cal.seconds));
                    report_field("minutes", 32'(want.cal.minutes), 32'(got_cal.minutes));
                    report_field("hours", 32'(want.cal.hours), 32'(got_cal.hours));
                    report_field("day", 32'(want.cal.day), 32'(got_cal.day));
                    report_field("month", 32'(want.cal.month), 32'(got_cal.month));
                    report_field("year", 32'(want.cal.year), 32'(got_cal.year));
                    report_field("second_strobe", 32'(want.strobe), 32'(m_tuser));
                end
            end
            if (hold_kick) begin
                hold_left <= 80;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end else if (sink_idle && $urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(1, 13) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset calendar at the reset rate, then the extremes of every field.
        queue_tick();
        queue_tick();
        queue_set(59, 59, 23, 30, 12, 65535);
        queue_tick();
        queue_set(63, 63, 31, 31, 15, 65535);
        queue_set(0, 0, 0, 0, 0, 0);
        queue_tick();

        // Full carry into the year wrap, oversized fields and zero day or month.
        write_tick_rate(16'd1);
        queue_set(59, 59, 23, 30, 12, 65535);
        queue_tick();
        queue_set(63, 63, 31, 31, 15, 43690);
        queue_tick();
        queue_set(0, 0, 0, 0, 0, 21845);
        queue_tick();
        queue_set(59, 59, 23, 0, 0, 100);
        queue_tick();
        queue_set(59, 59, 23, 30, 0, 7);
        queue_tick();

        write_tick_rate(16'd0);
        queue_tick();
        queue_tick();

        // A high rate leaves the prescaler ahead of a lower rate written next.
        write_tick_rate(16'hFFFF);
        repeat (6) queue_tick();
        write_tick_rate(16'd3);
        queue_tick();
        queue_tick();

        random_phase(16'd1, 300);
        random_phase(16'd2, 150);
        random_phase(16'd0, 100);
        random_phase(16'd3, 150);
        random_phase(16'd60, 150);
        random_phase(16'hFFFF, 60);
        random_phase(16'd4, 150);

        // Long receiver hold while the sender keeps offering transactions.
        write_tick_rate(16'd7);
        src_idle = 1'b0;
        sink_idle = 1'b0;
        queue_random(200);
        repeat (10) @(negedge aclk);
        hold_kick = 1'b1;
        @(negedge aclk);
        hold_kick = 1'b0;

        random_phase(16'($urandom_range(1, 100)), 150);
        random_phase(tdcc_pkg::RESET_TICK_RATE, 100);

        write_tick_rate(16'd1);
        src_idle = 1'b0;
        sink_idle = 1'b0;
        queue_random(200);
        wait_drained();
        repeat (10) @(negedge aclk);

        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/tdcc_pkg.sv
src/tdcc_calendar.sv
src/tick_driven_calendar_clock.sv
src/tdcc_checker.sv
dv/tick_driven_calendar_clock_tb.sv
